// ===== sv/sse_event_data_parser_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the SSE event data parser checker.
// Each macro expands to one labeled concurrent assertion clocked on clk_i
// and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SSE_EVENT_DATA_PARSER_UNIT_ASSERT_SVH
`define SSE_EVENT_DATA_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sse checker: assertion failed");

// Next-cycle implication.
`define SSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sse checker: assertion failed");

`endif

// ===== sv/sse_pkg.sv =====
// ---------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the SSE event data parser.
// ---------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

  // Store depth default and configuration register.
  localparam int unsigned MAX_EVENT_DEF = 64;
  localparam int unsigned CFG_W         = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Length field of a delivery command, covers the largest store depth.
  localparam int unsigned LEN_W = 7;

  // Command queue depth between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;

  // Result status codes.
  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FAIL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_DELIVER = 2'd0,
    CMD_EMPTY   = 2'd1,
    CMD_FAIL    = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/sse_event_data_parser_unit.sv =====
// ---------------------------------------------------------------------------
// sse_event_data_parser_unit
// Byte-serial server-sent events parser that keeps only the data field.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_byte_i): one stream byte per word.
//   Output channel (out_valid_o/out_ready_i): status_o, out_byte_o, last_o.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_cap_i): line and event
//   capacity, always ready; write it only while the block is idle.
//   Ordinary bytes are taken one per cycle while in_ready_o is high; they
//   update the line state and the event store, or queue a failed word.
//   A blank line closing an event with data queues a readout: its first
//   word passes the queue, read stage and output register, then one stored byte
//   per cycle while out_ready_i is high. in_ready_o stays low from the blank
//   line until the word with last_o is taken, since the readout uses the
//   store's single read port and the front writes the same store.
//   Empty-event and failed words pass through the same 2-entry command
//   queue, so the input keeps flowing while they wait.
//   When the receiver stalls, the output register holds its word, the read
//   stage and queue fill, then in_ready_o drops.
//   Reset clears all parser state and the failed flag and sets the capacity
//   to 64; the store is not cleared (only written bytes are ever read).
// ---------------------------------------------------------------------------
`default_nettype none

module sse_event_data_parser_unit #(
  parameter int unsigned MAX_EVENT = sse_pkg::MAX_EVENT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sse_pkg::CFG_W-1:0] cfg_cap_i,
  // byte input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [7:0]                out_byte_o,
  output logic                      last_o
);

  localparam int unsigned AW = (MAX_EVENT > 1) ? $clog2(MAX_EVENT) : 1;

  logic          q_full, q_push, q_valid, q_pop, done;
  sse_pkg::cmd_t q_cmd_in, q_cmd_out;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // register write never stalls
  assign cfg_ready_o = 1'b1;

  sse_front #(
    .MAX_EVENT(MAX_EVENT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_cap_i),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in),
    .done_i     (done),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // commands: deliver(len), empty event, failed
  sse_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .cmd_o  (q_cmd_out),
    .pop_i  (q_pop)
  );

  sse_back #(
    .MAX_EVENT(MAX_EVENT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (q_cmd_out),
    .pop_o       (q_pop),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .done_o      (done)
  );

endmodule

`default_nettype wire

// ===== sv/sse_front.sv =====
// ---------------------------------------------------------------------------
// sse_front
// Line parser: classifies each byte, writes data values into the event
// store and queues delivery, empty-event and failure commands.
// ---------------------------------------------------------------------------
`default_nettype none

module sse_front #(
  parameter int unsigned MAX_EVENT = sse_pkg::MAX_EVENT_DEF,
  localparam int unsigned CW = $clog2(MAX_EVENT + 1),
  localparam int unsigned AW = (MAX_EVENT > 1) ? $clog2(MAX_EVENT) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [sse_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic [7:0]                in_byte_i,
  output logic                      in_ready_o,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output sse_pkg::cmd_t             q_cmd_o,
  input  logic                      done_i,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic [7:0]                wr_data_o
);

  localparam int unsigned SW = CW + 1;
  localparam logic [sse_pkg::CFG_W-1:0] MaxEvCfg = sse_pkg::CFG_W'(MAX_EVENT);
  localparam logic [CW-1:0] MaxEvC = CW'(MAX_EVENT);
  localparam logic [SW-1:0] MaxEvS = SW'(MAX_EVENT);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_T     = 8'h74;

  // Line recognizer, one-hot.
  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_D      = 8'b0000_0010,
    PH_DA     = 8'b0000_0100,
    PH_DAT    = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_COLON  = 8'b0010_0000,
    PH_VALUE  = 8'b0100_0000,
    PH_IGNORE = 8'b1000_0000
  } phase_e;

  logic [sse_pkg::CFG_W-1:0] max_q, max_d;
  logic [CW-1:0] ev_q, ev_d, line_q, line_d, vlen_q, vlen_d;
  phase_e        phase_q, phase_d;
  logic          ev_open_q, ev_open_d;
  logic          acr_q, acr_d;
  logic          failed_q, failed_d;
  logic          pend_q, pend_d;

  logic          acc;
  logic [CW-1:0] cap;
  logic [SW-1:0] need;
  logic          is_eol;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !pend_q && !q_full_i;
  assign cap        = (max_q > MaxEvCfg) ? MaxEvC : max_q[CW-1:0];
  // Joined length after this value: also the store slot of the next value byte.
  assign need       = SW'(ev_q) + SW'(ev_open_q) + SW'(vlen_q);
  assign is_eol     = (in_byte_i == CHAR_CR) || (in_byte_i == CHAR_LF);

  always_comb begin
    max_d      = max_q;
    ev_d       = ev_q;
    line_d     = line_q;
    vlen_d     = vlen_q;
    phase_d    = phase_q;
    ev_open_d  = ev_open_q;
    acr_d      = acr_q;
    failed_d   = failed_q;
    pend_d     = pend_q;
    q_push_o   = 1'b0;
    q_cmd_o    = '{kind: sse_pkg::CMD_FAIL, len: '0};
    wr_en_o    = 1'b0;
    wr_addr_o  = need[AW-1:0];
    wr_data_o  = in_byte_i;

    if (cfg_valid_i) begin
      max_d = cfg_data_i;
    end
    if (done_i) begin
      pend_d = 1'b0;
    end

    if (acc) begin
      if (failed_q) begin
        q_push_o = 1'b1;
      end else if (acr_q && (in_byte_i == CHAR_LF)) begin
        acr_d = 1'b0;
      end else begin
        acr_d = 1'b0;
        if (is_eol) begin
          if (line_q == '0) begin
            // blank line closes the event
            if (ev_open_q) begin
              q_push_o = 1'b1;
              if (ev_q == '0) begin
                q_cmd_o.kind = sse_pkg::CMD_EMPTY;
              end else begin
                q_cmd_o.kind = sse_pkg::CMD_DELIVER;
                q_cmd_o.len  = sse_pkg::LEN_W'(ev_q);
                pend_d       = 1'b1;
              end
            end
            ev_open_d = 1'b0;
            ev_d      = '0;
          end else if ((phase_q == PH_COLON) || (phase_q == PH_VALUE)) begin
            if (need > SW'(cap)) begin
              failed_d = 1'b1;
              q_push_o = 1'b1;
            end else begin
              // separator LF between joined values
              if (ev_open_q && (ev_q < MaxEvC)) begin
                wr_en_o   = 1'b1;
                wr_addr_o = ev_q[AW-1:0];
                wr_data_o = CHAR_LF;
              end
              ev_d      = need[CW-1:0];
              ev_open_d = 1'b1;
            end
          end
          line_d  = '0;
          vlen_d  = '0;
          phase_d = PH_START;
          acr_d   = (in_byte_i == CHAR_CR);
        end else if (line_q >= cap) begin
          failed_d = 1'b1;
          q_push_o = 1'b1;
        end else begin
          line_d = line_q + CW'(1);
          case (phase_q)
            PH_START: phase_d = (in_byte_i == CHAR_D) ? PH_D : PH_IGNORE;
            PH_D:     phase_d = (in_byte_i == CHAR_A) ? PH_DA : PH_IGNORE;
            PH_DA:    phase_d = (in_byte_i == CHAR_T) ? PH_DAT : PH_IGNORE;
            PH_DAT:   phase_d = (in_byte_i == CHAR_A) ? PH_DATA : PH_IGNORE;
            PH_DATA:  phase_d = (in_byte_i == CHAR_COLON) ? PH_COLON : PH_IGNORE;
            PH_COLON: begin
              // one leading space is dropped
              if (in_byte_i != CHAR_SPACE) begin
                wr_en_o = (need < MaxEvS);
                vlen_d  = vlen_q + CW'(1);
              end
              phase_d = PH_VALUE;
            end
            PH_VALUE: begin
              wr_en_o = (need < MaxEvS);
              vlen_d  = vlen_q + CW'(1);
            end
            default: phase_d = PH_IGNORE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= sse_pkg::CFG_RESET;
      ev_q      <= '0;
      line_q    <= '0;
      vlen_q    <= '0;
      phase_q   <= PH_START;
      ev_open_q <= 1'b0;
      acr_q     <= 1'b0;
      failed_q  <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      max_q     <= max_d;
      ev_q      <= ev_d;
      line_q    <= line_d;
      vlen_q    <= vlen_d;
      phase_q   <= phase_d;
      ev_open_q <= ev_open_d;
      acr_q     <= acr_d;
      failed_q  <= failed_d;
      pend_q    <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sse_cmdq.sv =====
// ---------------------------------------------------------------------------
// sse_cmdq
// Small command FIFO between parser front and delivery back.
// ---------------------------------------------------------------------------
`default_nettype none

module sse_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sse_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output sse_pkg::cmd_t cmd_o,
  input  logic          pop_i
);

  localparam int unsigned Depth = sse_pkg::CMDQ_DEPTH;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW    = $clog2(Depth + 1);

  sse_pkg::cmd_t  slot_q [Depth];
  logic [PW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == NW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(Depth - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(Depth - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sse_back.sv =====
// ---------------------------------------------------------------------------
// sse_back
// Event store and delivery: executes queued commands, reads stored bytes
// out one per cycle unless stalled, via a read stage and an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sse_back #(
  parameter int unsigned MAX_EVENT = sse_pkg::MAX_EVENT_DEF,
  localparam int unsigned AW = (MAX_EVENT > 1) ? $clog2(MAX_EVENT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  sse_pkg::cmd_t head_i,
  output logic          pop_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic          done_o
);

  localparam int unsigned LW = sse_pkg::LEN_W;

  logic [7:0]    store_q [MAX_EVENT];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] idx_q, idx_d;

  // read stage
  logic          rd_v_q, rd_v_d;
  logic [1:0]    rd_status_q, rd_status_d;
  logic          rd_last_q, rd_last_d;
  logic          rd_mem_q, rd_mem_d;

  // output register
  logic          out_v_q, out_v_d;
  logic [1:0]    out_status_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic          adv, can_issue, issue, rd_en, is_last;

  assign adv       = rd_v_q && (!out_v_q || out_ready_i);
  assign can_issue = !rd_v_q || adv;
  assign issue     = head_valid_i && can_issue;
  assign is_last   = (LW'(idx_q) == (head_i.len - LW'(1)));

  always_comb begin
    rd_v_d      = rd_v_q;
    rd_status_d = rd_status_q;
    rd_last_d   = rd_last_q;
    rd_mem_d    = rd_mem_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    if (issue) begin
      rd_v_d = 1'b1;
      case (head_i.kind)
        sse_pkg::CMD_DELIVER: begin
          rd_status_d = sse_pkg::STATUS_DATA;
          rd_last_d   = is_last;
          rd_mem_d    = 1'b1;
          rd_en       = 1'b1;
          pop_o       = is_last;
          idx_d       = is_last ? '0 : idx_q + AW'(1);
        end
        sse_pkg::CMD_EMPTY: begin
          rd_status_d = sse_pkg::STATUS_EMPTY;
          rd_last_d   = 1'b1;
          rd_mem_d    = 1'b0;
          pop_o       = 1'b1;
        end
        default: begin
          rd_status_d = sse_pkg::STATUS_FAIL;
          rd_last_d   = 1'b0;
          rd_mem_d    = 1'b0;
          pop_o       = 1'b1;
        end
      endcase
    end else if (adv) begin
      rd_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (adv) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // store: front writes, delivery reads with registered data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= store_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_status_q <= rd_status_d;
    rd_last_q   <= rd_last_d;
    rd_mem_q    <= rd_mem_d;
    if (adv) begin
      out_status_q <= rd_status_q;
      out_byte_q   <= rd_mem_q ? rd_data_q : 8'd0;
      out_last_q   <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      rd_v_q  <= rd_v_d;
      out_v_q <= out_v_d;
      idx_q   <= idx_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_status_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign done_o      = out_v_q && out_ready_i && out_last_q
                       && (out_status_q == sse_pkg::STATUS_DATA);

endmodule

`default_nettype wire

// ===== sv/sse_chk.sv =====
// ---------------------------------------------------------------------------
// sse_chk
// Port-level checker for the SSE event data parser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sse_event_data_parser_unit_assert.svh"

module sse_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] out_byte_o,
  input logic       last_o
);

  // stalled output word holds
  `SSE_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(out_byte_o) && $stable(last_o))

  // failed word carries no byte and no last mark
  `SSE_ASSERT_IMP(a_fail_word, out_valid_o && (status_o == sse_pkg::STATUS_FAIL), (out_byte_o == 8'd0) && !last_o)

  // empty event is a single closing word
  `SSE_ASSERT_IMP(a_empty_word, out_valid_o && (status_o == sse_pkg::STATUS_EMPTY), (out_byte_o == 8'd0) && last_o)

  // input is held off during event readout
  `SSE_ASSERT_IMP(a_readout_stall, out_valid_o && (status_o == sse_pkg::STATUS_DATA), !in_ready_o)

endmodule

bind sse_event_data_parser_unit sse_chk u_chk (.*);

`default_nettype wire
